/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* rtl/core/bal_pkg.sv */
`default_nettype none
package bal_pkg;
   localparam int MAX_ORDER_DEF  = 10;
   localparam int LIST_DEPTH_DEF = 512;
   localparam int SIZE_W = 11;
   localparam int ADDR_W = 10;
   localparam int ORD_W  = 4;
   localparam int CNT_W  = 4;
   localparam logic [3:0] POOL_ORDER_RST = 4'd10;

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FAIL    = 2'd1,
      ST_BADFREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_SEED, S_IDLE, S_FIND, S_HEAD, S_SHIFT_RD, S_SHIFT_WR, S_SPLIT,
      S_MAP_RD, S_MERGE, S_SCAN, S_SCAN_CMP, S_PUSH, S_DONE
   } state_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [ADDR_W-1:0] addr;
      logic [ORD_W-1:0]  order;
      logic [CNT_W-1:0]  merges;
   } res_type;
endpackage
`default_nettype wire

/* rtl/core/bal_ram.sv */
`default_nettype none
module bal_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* rtl/core/bal_seq.sv */
`default_nettype none
module bal_seq import bal_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire cmd_type           req_cmd,
   input  wire logic [SIZE_W-1:0] req_size,
   input  wire logic [ADDR_W-1:0] req_faddr,
   input  wire logic [3:0]        pool_order,
   input  wire logic              out_free,
   output      res_type           res
);
   localparam int MAX_ORDER = MAX_ORDER_DEF;
   localparam int NUM_ORD = MAX_ORDER + 1;
   localparam int OW  = $clog2(NUM_ORD);
   localparam int MW  = $clog2(MAX_ORDER + 2);
   localparam int AW  = MAX_ORDER;
   localparam int CW  = $clog2(LIST_DEPTH + 1);
   localparam int LAW = $clog2(NUM_ORD * LIST_DEPTH);

   state_type      state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [OW-1:0]  ord_ff, ord_in, x_ff, x_in, merges_ff, merges_in;
   logic [AW-1:0]  addr_ff, addr_in, clr_ff, clr_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [CW-1:0]  counts_ff [NUM_ORD];
   logic [CW-1:0]  counts_in [NUM_ORD];
   res_type        res_ff, res_in;

   logic           l_we;
   logic [LAW-1:0] l_waddr, l_raddr;
   logic [AW-1:0]  l_wdata, l_rdata;
   logic           m_we;
   logic [AW-1:0]  m_waddr, m_raddr;
   logic [MW-1:0]  m_wdata, m_rdata;

   logic [SIZE_W-1:0] szm1;
   logic [4:0]        x_c;
   logic              size_bad, faddr_bad;
   logic [OW-1:0]     po_sat, ord_dn;
   logic [AW-1:0]     bit_ord, bit_dn;

   bal_ram #(.WIDTH(AW), .DEPTH(NUM_ORD * LIST_DEPTH)) u_lists (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata(l_rdata)
   );

   bal_ram #(.WIDTH(MW), .DEPTH(1 << MAX_ORDER)) u_map (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
      .raddr(m_raddr), .rdata(m_rdata)
   );

   function automatic logic [LAW-1:0] slot(input logic [OW-1:0] o, input logic [CW-1:0] k);
      slot = LAW'(32'(o) * LIST_DEPTH) + LAW'(k);
   endfunction

   // size rounded up to a power of two: bit length of size-1
   always_comb begin
      szm1 = req_size - SIZE_W'(1);
      x_c  = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if ((szm1 >> i) != '0) begin
            x_c = 5'(i + 1);
         end
      end
   end

   assign size_bad  = (req_size == '0) || (32'(x_c) > MAX_ORDER);
   assign faddr_bad = (32'(req_faddr) >> MAX_ORDER) != 0;
   assign po_sat    = (32'(pool_order) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(pool_order);
   assign ord_dn    = ord_ff - OW'(1);
   assign bit_ord   = AW'(1) << ord_ff;
   assign bit_dn    = AW'(1) << ord_dn;
   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cmd_ff   <= CMD_NONE;
         clr_ff   <= '0;
         for (int i = 0; i < NUM_ORD; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         cmd_ff    <= cmd_in;
         clr_ff    <= clr_in;
         counts_ff <= counts_in;
      end
      ord_ff    <= ord_in;
      x_ff      <= x_in;
      merges_ff <= merges_in;
      addr_ff   <= addr_in;
      k_ff      <= k_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      ord_in    = ord_ff;
      x_in      = x_ff;
      merges_in = merges_ff;
      addr_in   = addr_ff;
      clr_in    = clr_ff;
      k_in      = k_ff;
      counts_in = counts_ff;
      res_in    = res_ff;
      l_we      = 1'b0;
      l_waddr   = slot(ord_ff, counts_ff[ord_ff]);
      l_wdata   = addr_ff;
      l_raddr   = slot(ord_ff, k_ff);
      m_we      = 1'b0;
      m_waddr   = addr_ff;
      m_wdata   = '0;
      m_raddr   = AW'(req_faddr);

      case (state_ff)
         S_CLEAR: begin
            m_we    = 1'b1;
            m_waddr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = S_SEED;
            end
         end
         S_SEED: begin
            l_we              = 1'b1;
            l_waddr           = slot(po_sat, '0);
            l_wdata           = '0;
            counts_in[po_sat] = CW'(1);
            res_in            = '{valid: 1'b0, status: ST_OK, addr: '0,
                                  order: ORD_W'(po_sat), merges: '0};
            state_in          = (cmd_ff == CMD_INIT) ? S_DONE : S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               res_in = '{valid: 1'b0, status: ST_FAIL, addr: '0, order: '0, merges: '0};
               case (req_cmd)
                  CMD_INIT: begin
                     clr_in = '0;
                     for (int i = 0; i < NUM_ORD; i++) begin
                        counts_in[i] = '0;
                     end
                     state_in = S_CLEAR;
                  end
                  CMD_ALLOC: begin
                     x_in   = OW'(x_c);
                     ord_in = OW'(x_c);
                     state_in = size_bad ? S_DONE : S_FIND;
                  end
                  CMD_FREE: begin
                     addr_in = AW'(req_faddr);
                     if (faddr_bad) begin
                        res_in.status = ST_BADFREE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_MAP_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FIND: begin
            l_raddr = slot(ord_ff, '0);
            if (counts_ff[ord_ff] != '0) begin
               state_in = S_HEAD;
            end else if (32'(ord_ff) == MAX_ORDER) begin
               state_in = S_DONE;
            end else begin
               ord_in = ord_ff + OW'(1);
            end
         end
         S_HEAD: begin
            addr_in  = l_rdata;
            k_in     = CW'(1);
            state_in = S_SHIFT_RD;
         end
         // remove one entry: move each later entry down one slot
         S_SHIFT_RD: begin
            if (k_ff < counts_ff[ord_ff]) begin
               state_in = S_SHIFT_WR;
            end else begin
               counts_in[ord_ff] = counts_ff[ord_ff] - CW'(1);
               if (cmd_ff == CMD_ALLOC) begin
                  state_in = S_SPLIT;
               end else begin
                  addr_in   = addr_ff & ~bit_ord;
                  ord_in    = ord_ff + OW'(1);
                  merges_in = merges_ff + OW'(1);
                  state_in  = S_MERGE;
               end
            end
         end
         S_SHIFT_WR: begin
            l_we     = 1'b1;
            l_waddr  = slot(ord_ff, k_ff - CW'(1));
            l_wdata  = l_rdata;
            k_in     = k_ff + CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_SPLIT: begin
            if (ord_ff > x_ff) begin
               ord_in  = ord_dn;
               l_waddr = slot(ord_dn, counts_ff[ord_dn]);
               l_wdata = addr_ff + bit_dn;
               if (32'(counts_ff[ord_dn]) < LIST_DEPTH) begin
                  l_we              = 1'b1;
                  counts_in[ord_dn] = counts_ff[ord_dn] + CW'(1);
               end
            end else begin
               m_we     = 1'b1;
               m_wdata  = MW'(x_ff) + MW'(1);
               res_in   = '{valid: 1'b0, status: ST_OK, addr: ADDR_W'(addr_ff),
                            order: ORD_W'(x_ff), merges: '0};
               state_in = S_DONE;
            end
         end
         S_MAP_RD: begin
            if (m_rdata == '0 || 32'(m_rdata) > NUM_ORD) begin
               res_in.status = ST_BADFREE;
               state_in      = S_DONE;
            end else begin
               m_we      = 1'b1;
               ord_in    = OW'(m_rdata - MW'(1));
               merges_in = '0;
               state_in  = S_MERGE;
            end
         end
         S_MERGE: begin
            k_in     = '0;
            state_in = (32'(ord_ff) >= MAX_ORDER) ? S_PUSH : S_SCAN;
         end
         S_SCAN: begin
            state_in = (k_ff < counts_ff[ord_ff]) ? S_SCAN_CMP : S_PUSH;
         end
         S_SCAN_CMP: begin
            k_in = k_ff + CW'(1);
            state_in = (l_rdata == (addr_ff ^ bit_ord)) ? S_SHIFT_RD : S_SCAN;
         end
         S_PUSH: begin
            if (32'(counts_ff[ord_ff]) < LIST_DEPTH) begin
               l_we              = 1'b1;
               counts_in[ord_ff] = counts_ff[ord_ff] + CW'(1);
            end
            res_in   = '{valid: 1'b0, status: ST_OK, addr: ADDR_W'(addr_ff),
                         order: ORD_W'(ord_ff), merges: CNT_W'(merges_ff)};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res       = res_ff;
      res.valid = (state_ff == S_DONE) && out_free;
   end
endmodule
`default_nettype wire

/* rtl/core/buddy_allocator.sv */
// Steps to rsp_tvalid: init runs the map clearing pass, then the seed step, then done.
// Allocate: search the orders upward, take the list head, shift the entries behind it down, then split.
// Free: read the map, scan the list for the buddy, and per merge shift the entries behind it down.
// One item at a time through a single list memory; ready only when idle.
// Reset (synchronous, active high) runs the same clearing pass and seed step before ready rises.
`default_nettype none
`include "assert_macros.svh"
module buddy_allocator import bal_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,  // request_size[10:0], free_address[20:11]
   input  wire logic [1:0]  req_tuser,  // cmd[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,  // block_address[9:0], block_order[13:10],
                                        // merge_count[17:14]
   output      logic [1:0]  rsp_tuser,  // status[1:0]
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [3:0]  csr_data
);
   localparam int MAX_ORDER = MAX_ORDER_DEF;

   logic [3:0]  pool_order_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;
   logic        out_free;
   res_type     res;

   bal_seq #(.LIST_DEPTH(LIST_DEPTH)) u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready),
      .req_cmd(cmd_type'(req_tuser)), .req_size(req_tdata[10:0]),
      .req_faddr(req_tdata[20:11]), .pool_order(pool_order_ff),
      .out_free(out_free), .res(res)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, res.merges, res.order, res.addr};
         rsp_user_in  = res.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_order_ff <= POOL_ORDER_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            pool_order_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_NEVER(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_OK && rsp_tdata != '0)
   `ASSERT_IMPLIES(a_clear_busy, clock, reset, $fell(reset), !req_tready)
   `ASSERT_IMPLIES(a_ok_order, clock, reset, rsp_tvalid && rsp_tuser == ST_OK, 32'(rsp_tdata[13:10]) <= MAX_ORDER)
endmodule
`default_nettype wire
